@@ src/abrs_pkg.sv @@
package abrs_pkg;

  localparam int SPEED_W  = 16;
  localparam int HEAD_W   = 9;
  localparam int TIMER_W  = 16;
  localparam int RATE_W   = 16;
  localparam int MPHS_W   = 8;
  localparam int ACC_W    = 12;
  localparam int STEP_W   = 11;
  localparam int MPH_W    = 26;
  localparam int MUL_A_W  = 16;
  localparam int PROD_W   = MUL_A_W + MPH_W;
  localparam int FH_W     = RATE_W + MPHS_W;
  localparam int DIV_W    = 16;
  localparam int CNT_W    = 4;
  localparam int PADDR_W  = 5;
  localparam int PDATA_W  = 32;
  localparam int RIDX_W   = 3;

  // round(1.15078 / 100 * 2^32): centiknots to mph in Q32
  localparam logic [MPH_W-1:0] MPH_Q32_PER_CK = 26'd49425625;

  localparam logic [TIMER_W-1:0] TIMER_MAX = 16'hFFFF;
  localparam logic signed [ACC_W:0] ACC_MAX = 13'sd2047;
  localparam logic signed [ACC_W:0] ACC_MIN = -13'sd2048;
  localparam logic signed [STEP_W-1:0] HALF_TURN = 11'sd180;
  localparam logic signed [STEP_W-1:0] FULL_TURN = 11'sd360;

  localparam logic [RIDX_W-1:0] REG_STATIC_RATE  = 3'd0;
  localparam logic [RIDX_W-1:0] REG_LOW_SPEED    = 3'd1;
  localparam logic [RIDX_W-1:0] REG_SLOW_RATE    = 3'd2;
  localparam logic [RIDX_W-1:0] REG_HIGH_SPEED   = 3'd3;
  localparam logic [RIDX_W-1:0] REG_FAST_RATE    = 3'd4;
  localparam logic [RIDX_W-1:0] REG_TURN_MINIMUM = 3'd5;
  localparam logic [RIDX_W-1:0] REG_TURN_HOLD    = 3'd6;
  localparam logic [RIDX_W-1:0] REG_TURN_SLOPE   = 3'd7;

  localparam logic [RATE_W-1:0] RST_STATIC_RATE  = 16'd900;
  localparam logic [MPHS_W-1:0] RST_LOW_SPEED    = 8'd5;
  localparam logic [RATE_W-1:0] RST_SLOW_RATE    = 16'd1800;
  localparam logic [MPHS_W-1:0] RST_HIGH_SPEED   = 8'd60;
  localparam logic [RATE_W-1:0] RST_FAST_RATE    = 16'd180;
  localparam logic [MPHS_W-1:0] RST_TURN_MINIMUM = 8'd30;
  localparam logic [RATE_W-1:0] RST_TURN_HOLD    = 16'd15;
  localparam logic [RATE_W-1:0] RST_TURN_SLOPE   = 16'd255;

endpackage

@@ src/abrs_in_if.sv @@
interface abrs_in_if import abrs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SPEED_W-1:0]  speed_centiknots;
  logic [HEAD_W-1:0]   heading_deg;
  logic                fix_valid;

  modport source (output valid, output speed_centiknots, output heading_deg,
                  output fix_valid, input ready);
  modport sink (input valid, input speed_centiknots, input heading_deg,
                input fix_valid, output ready);
endinterface

@@ src/abrs_out_if.sv @@
interface abrs_out_if import abrs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                send_beacon;
  logic [RATE_W-1:0]   interval_now;
  logic [TIMER_W-1:0]  elapsed;

  modport source (output valid, output send_beacon, output interval_now,
                  output elapsed, input ready);
  modport sink (input valid, input send_beacon, input interval_now,
                input elapsed, output ready);
endinterface

@@ src/adaptive_beacon_rate_scheduler.sv @@
// Each input beat is taken in the idle state, then makes three passes through the
// one shared multiplier, 16 divider steps and a commit step; no new beat is taken
// until the result is committed.
// A waiting result stalls the commit cycle only until the output slot frees.
// Reset (rst_n low, synchronous) loads register defaults, clears the timer,
// heading state and output valid, and arms the startup beacon.
module adaptive_beacon_rate_scheduler import abrs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  abrs_in_if.sink            in_chan,
  abrs_out_if.source         out_chan,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MPH  = 3'd1;
  localparam logic [2:0] S_FH   = 3'd2;
  localparam logic [2:0] S_TURN = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [RATE_W-1:0] static_rate_r, slow_rate_r, fast_rate_r, turn_hold_r, turn_slope_r;
  logic [MPHS_W-1:0] low_speed_r, high_speed_r, turn_minimum_r;

  logic [TIMER_W-1:0]      tick_r;
  logic [RATE_W-1:0]       interval_r;
  logic [HEAD_W-1:0]       prior_r;
  logic signed [ACC_W-1:0] accum_r;
  logic                    startup_r;
  logic                    primed_r;

  logic [2:0]              state_r, state_nxt;
  logic [SPEED_W-1:0]      speed_r;
  logic [HEAD_W-1:0]       heading_r;
  logic                    fix_r;
  logic [MPH_W-1:0]        mph_r;
  logic signed [ACC_W-1:0] acc_new_r;
  logic [ACC_W-1:0]        turn_diff_r;
  logic                    corner_r;
  logic                    sat_r;
  logic [MPH_W-1:0]        rem_r;
  logic [DIV_W-1:0]        quo_r;
  logic [CNT_W-1:0]        cnt_r;

  logic                    out_valid_r, out_send_r;
  logic [RATE_W-1:0]       out_int_r;
  logic [TIMER_W-1:0]      out_el_r;

  logic                    cfg_wr;
  logic [RIDX_W-1:0]       cfg_idx;

  logic [MUL_A_W-1:0]      mul_a;
  logic [MPH_W-1:0]        mul_b;
  logic [PROD_W-1:0]       prod;

  logic                    due;
  logic signed [ACC_W-1:0] acc_base;
  logic signed [STEP_W-1:0] h_diff, step;
  logic signed [ACC_W:0]   acc_sum, acc_sat;
  logic [ACC_W:0]          acc_abs;
  logic [ACC_W-1:0]        mag;
  logic                    mag_gt;
  logic [ACC_W-1:0]        turn_diff;

  logic [MPH_W:0]          rem2;
  logic                    rem_ge;
  logic [MPH_W:0]          rem_sub;

  logic                    out_free, commit, hold_all, static_mode, corner_fire;
  logic [RATE_W-1:0]       sp_int, int_nxt;
  logic [TIMER_W-1:0]      tc_base, tc_mid, tc_nxt;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      static_rate_r  <= RST_STATIC_RATE;
      low_speed_r    <= RST_LOW_SPEED;
      slow_rate_r    <= RST_SLOW_RATE;
      high_speed_r   <= RST_HIGH_SPEED;
      fast_rate_r    <= RST_FAST_RATE;
      turn_minimum_r <= RST_TURN_MINIMUM;
      turn_hold_r    <= RST_TURN_HOLD;
      turn_slope_r   <= RST_TURN_SLOPE;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_STATIC_RATE:  static_rate_r  <= pwdata[RATE_W-1:0];
        REG_LOW_SPEED:    low_speed_r    <= pwdata[MPHS_W-1:0];
        REG_SLOW_RATE:    slow_rate_r    <= pwdata[RATE_W-1:0];
        REG_HIGH_SPEED:   high_speed_r   <= pwdata[MPHS_W-1:0];
        REG_FAST_RATE:    fast_rate_r    <= pwdata[RATE_W-1:0];
        REG_TURN_MINIMUM: turn_minimum_r <= pwdata[MPHS_W-1:0];
        REG_TURN_HOLD:    turn_hold_r    <= pwdata[RATE_W-1:0];
        REG_TURN_SLOPE:   turn_slope_r   <= pwdata[RATE_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_STATIC_RATE:  prdata = PDATA_W'(static_rate_r);
      REG_LOW_SPEED:    prdata = PDATA_W'(low_speed_r);
      REG_SLOW_RATE:    prdata = PDATA_W'(slow_rate_r);
      REG_HIGH_SPEED:   prdata = PDATA_W'(high_speed_r);
      REG_FAST_RATE:    prdata = PDATA_W'(fast_rate_r);
      REG_TURN_MINIMUM: prdata = PDATA_W'(turn_minimum_r);
      REG_TURN_HOLD:    prdata = PDATA_W'(turn_hold_r);
      REG_TURN_SLOPE:   prdata = PDATA_W'(turn_slope_r);
    endcase
  end

  // shared multiplier
  always_comb begin
    unique case (state_r)
      S_MPH: begin
        mul_a = speed_r;
        mul_b = MPH_Q32_PER_CK;
      end
      S_FH: begin
        mul_a = fast_rate_r;
        mul_b = MPH_W'(high_speed_r);
      end
      S_TURN: begin
        mul_a = MUL_A_W'(turn_diff_r);
        mul_b = mph_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

  // heading step and accumulator
  assign due      = startup_r | (tick_r >= interval_r);
  assign acc_base = due ? '0 : accum_r;
  assign h_diff   = $signed(STEP_W'(heading_r)) - $signed(STEP_W'(prior_r));

  always_comb begin
    if (!primed_r) begin
      step = '0;
    end else if (h_diff > HALF_TURN) begin
      step = h_diff - FULL_TURN;
    end else if (h_diff <= -HALF_TURN) begin
      step = h_diff + FULL_TURN;
    end else begin
      step = h_diff;
    end
    acc_sum = $signed({acc_base[ACC_W-1], acc_base}) +
              $signed({{(ACC_W+1-STEP_W){step[STEP_W-1]}}, step});
    if (acc_sum > ACC_MAX) begin
      acc_sat = ACC_MAX;
    end else if (acc_sum < ACC_MIN) begin
      acc_sat = ACC_MIN;
    end else begin
      acc_sat = acc_sum;
    end
  end

  assign acc_abs   = acc_new_r[ACC_W-1] ? (-$signed({acc_new_r[ACC_W-1], acc_new_r}))
                                        : {1'b0, acc_new_r};
  assign mag       = acc_abs[ACC_W-1:0];
  assign mag_gt    = mag > ACC_W'(turn_minimum_r);
  assign turn_diff = mag_gt ? (mag - ACC_W'(turn_minimum_r)) : '0;

  // one restoring step a cycle
  assign rem2    = {rem_r, 1'b0};
  assign rem_ge  = rem2 >= {1'b0, mph_r};
  assign rem_sub = rem2 - {1'b0, mph_r};

  // commit
  assign out_free    = !out_valid_r || out_chan.ready;
  assign commit      = (state_r == S_DONE) && out_free;
  assign hold_all    = due && !fix_r;
  assign static_mode = static_rate_r != '0;

  always_comb begin
    if (mph_r < {2'b00, low_speed_r, 16'b0}) begin
      sp_int = slow_rate_r;
    end else if (mph_r > {2'b00, high_speed_r, 16'b0}) begin
      sp_int = fast_rate_r;
    end else if (sat_r) begin
      sp_int = TIMER_MAX;
    end else begin
      sp_int = quo_r;
    end
    int_nxt     = static_mode ? static_rate_r : sp_int;
    tc_base     = due ? '0 : tick_r;
    corner_fire = !static_mode && corner_r && (tc_base > turn_hold_r);
    tc_mid      = corner_fire ? int_nxt : tc_base;
    tc_nxt      = (tc_mid == TIMER_MAX) ? TIMER_MAX : tc_mid + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r     <= '0;
      interval_r <= RST_STATIC_RATE;
      prior_r    <= '0;
      accum_r    <= '0;
      startup_r  <= 1'b1;
      primed_r   <= 1'b0;
    end else if (commit && !hold_all) begin
      tick_r     <= tc_nxt;
      interval_r <= int_nxt;
      startup_r  <= 1'b0;
      if (static_mode) begin
        accum_r  <= acc_base;
        primed_r <= 1'b0;
      end else begin
        accum_r  <= acc_new_r;
        prior_r  <= heading_r;
        primed_r <= 1'b1;
      end
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_chan.valid) state_nxt = S_MPH;
      S_MPH:  state_nxt = S_FH;
      S_FH:   state_nxt = S_TURN;
      S_TURN: state_nxt = S_DIV;
      S_DIV:  if (cnt_r == CNT_W'(DIV_W - 1)) state_nxt = S_DONE;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        speed_r   <= in_chan.speed_centiknots;
        heading_r <= in_chan.heading_deg;
        fix_r     <= in_chan.fix_valid;
      end
      S_MPH: begin
        mph_r     <= prod[PROD_W-1:16];
        acc_new_r <= acc_sat[ACC_W-1:0];
      end
      S_FH: begin
        rem_r       <= MPH_W'(prod[FH_W-1:0]);
        sat_r       <= MPH_W'(prod[FH_W-1:0]) >= mph_r;
        quo_r       <= '0;
        cnt_r       <= '0;
        turn_diff_r <= turn_diff;
      end
      S_TURN: begin
        corner_r <= (mph_r != '0) && mag_gt && (prod > PROD_W'({turn_slope_r, 16'b0}));
      end
      S_DIV: begin
        rem_r <= rem_ge ? rem_sub[MPH_W-1:0] : rem2[MPH_W-1:0];
        quo_r <= {quo_r[DIV_W-2:0], rem_ge};
        cnt_r <= cnt_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

  // output slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      if (hold_all) begin
        out_send_r <= 1'b0;
        out_int_r  <= interval_r;
        out_el_r   <= tick_r;
      end else begin
        out_send_r <= due;
        out_int_r  <= int_nxt;
        out_el_r   <= tc_nxt;
      end
    end
  end

  assign in_chan.ready         = state_r == S_IDLE;
  assign out_chan.valid        = out_valid_r;
  assign out_chan.send_beacon  = out_send_r;
  assign out_chan.interval_now = out_int_r;
  assign out_chan.elapsed      = out_el_r;

endmodule

@@ src/abrs_chk.sv @@
module abrs_chk import abrs_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               send_beacon,
  input logic [RATE_W-1:0]  interval_now,
  input logic [TIMER_W-1:0] elapsed
);

  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again during work");

  a_beacon_restarts_timer: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && send_beacon |-> elapsed == TIMER_W'(1))
    else $error("beacon without timer restart");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("reset left result or busy state");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(send_beacon) &&
      $stable(interval_now) && $stable(elapsed))
    else $error("stalled result beat changed");

endmodule

bind adaptive_beacon_rate_scheduler abrs_chk u_abrs_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_chan.valid),
  .in_ready     (in_chan.ready),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .send_beacon  (out_chan.send_beacon),
  .interval_now (out_chan.interval_now),
  .elapsed      (out_chan.elapsed)
);
